// ===== hw/rtl/rbac_pkg.sv =====
// Shared types and constants for the rotating beacon angle capture block.
`default_nettype none

package rbac_pkg;

  // Event codes carried in the command field
  localparam logic CMD_INDEX = 1'b0;
  localparam logic CMD_LIGHT = 1'b1;

  // Light level after an edge
  localparam logic LIGHT_SEEN = 1'b0;
  localparam logic LIGHT_LOST = 1'b1;

  // Input request
  typedef struct packed {
    logic        command;
    logic [31:0] event_time;
    logic        light_absent;
  } in_t;

  // Result request
  typedef struct packed {
    logic [15:0] onset_angle;
    logic [15:0] arc_length;
  } out_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_FIN
  } ctl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic index_upd;  // shift index times, store new index time
    logic capture;    // latch light edge time and level
    logic prep;       // form delta and period, seed the divider
    logic step;       // one restoring divide step
    logic commit;     // update start angle / active flag, load result
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_emit;  // pending light edge produces a result
  } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rbac_datapath.sv =====
// Datapath: index times, bit-serial fraction divider, angle state, result register.
`default_nettype none

module rbac_datapath #(
  parameter int TIME_BITS  = 32,
  parameter int ANGLE_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire rbac_pkg::cmd_t cmd,
  input  wire rbac_pkg::in_t  in_data,
  output rbac_pkg::sts_t      sts,
  output rbac_pkg::out_t      out_data
);
  import rbac_pkg::*;

  logic [TIME_BITS-1:0]  prev_r, last_r, t_r, rem_r, den_r;
  logic [TIME_BITS-1:0]  prev_nxt, last_nxt, t_nxt, rem_nxt, den_nxt;
  logic [ANGLE_BITS-1:0] held_r, held_nxt, q_r, q_nxt;
  logic                  active_r, active_nxt, absent_r, absent_nxt, zero_r, zero_nxt;
  out_t                  out_r, out_nxt;

  logic [63:0]           t_ext;
  logic [TIME_BITS-1:0]  t_in, delta, period;
  logic [TIME_BITS:0]    shifted, diff;
  logic                  ge;
  logic [ANGLE_BITS-1:0] pos, len;
  logic [31:0]           held_w, len_w;

  // Event time taken modulo 2^TIME_BITS
  assign t_ext = {32'd0, in_data.event_time};
  assign t_in  = t_ext[TIME_BITS-1:0];

  // Time differences, modulo 2^TIME_BITS
  assign delta  = t_r - last_r;
  assign period = last_r - prev_r;

  // Restoring divide step: shift remainder, subtract divisor when it fits
  assign shifted = {rem_r, 1'b0};
  assign diff    = shifted - {1'b0, den_r};
  assign ge      = (shifted >= {1'b0, den_r});

  // Position and arc length
  assign pos    = zero_r ? '0 : q_r;
  assign len    = pos - held_r;
  assign held_w = 32'(held_r);
  assign len_w  = 32'(len);

  assign sts.need_emit = (absent_r == LIGHT_LOST) && active_r;
  assign out_data      = out_r;

  always_comb begin
    prev_nxt   = prev_r;
    last_nxt   = last_r;
    t_nxt      = t_r;
    absent_nxt = absent_r;
    rem_nxt    = rem_r;
    den_nxt    = den_r;
    q_nxt      = q_r;
    zero_nxt   = zero_r;
    held_nxt   = held_r;
    active_nxt = active_r;
    out_nxt    = out_r;

    if (cmd.index_upd) begin
      prev_nxt = last_r;
      last_nxt = t_in;
    end
    if (cmd.capture) begin
      t_nxt      = t_in;
      absent_nxt = in_data.light_absent;
    end
    if (cmd.prep) begin
      rem_nxt  = delta;
      den_nxt  = period;
      q_nxt    = '0;
      zero_nxt = !(delta < period);
    end
    if (cmd.step) begin
      rem_nxt = ge ? diff[TIME_BITS-1:0] : shifted[TIME_BITS-1:0];
      q_nxt   = {q_r[ANGLE_BITS-2:0], ge};
    end
    if (cmd.commit) begin
      if (absent_r == LIGHT_SEEN) begin
        held_nxt   = pos;
        active_nxt = 1'b1;
      end else if (active_r) begin
        out_nxt.onset_angle = held_w[15:0];
        out_nxt.arc_length  = len_w[15:0];
        active_nxt          = 1'b0;
      end
    end
  end

  // Architectural state, reset to its defined values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= '0;
      last_r   <= TIME_BITS'(1);
      held_r   <= '0;
      active_r <= 1'b0;
    end else begin
      prev_r   <= prev_nxt;
      last_r   <= last_nxt;
      held_r   <= held_nxt;
      active_r <= active_nxt;
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    t_r      <= t_nxt;
    absent_r <= absent_nxt;
    rem_r    <= rem_nxt;
    den_r    <= den_nxt;
    q_r      <= q_nxt;
    zero_r   <= zero_nxt;
    out_r    <= out_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rbac_ctrl.sv =====
// Controller: request handshake, divide sequencing and result valid.
`default_nettype none

module rbac_ctrl #(
  parameter int ANGLE_BITS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic           in_command,
  input  wire logic           out_stall,
  input  wire rbac_pkg::sts_t sts,
  output logic                in_stall,
  output logic                out_valid,
  output rbac_pkg::cmd_t      cmd
);
  import rbac_pkg::*;

  localparam int CW = $clog2(ANGLE_BITS);

  ctl_state_t    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          last_step, can_commit;

  assign last_step  = (cnt_r == CW'(ANGLE_BITS - 1));
  assign can_commit = !sts.need_emit || !out_valid_r || !out_stall;
  assign in_stall   = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid && in_command == CMD_LIGHT) state_nxt = ST_PREP;
      ST_PREP: state_nxt = ST_DIV;
      ST_DIV:  if (last_step) state_nxt = ST_FIN;
      ST_FIN:  if (can_commit) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd     = '0;
    cnt_nxt = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.index_upd = in_valid && (in_command == CMD_INDEX);
        cmd.capture   = in_valid && (in_command == CMD_LIGHT);
      end
      ST_PREP: begin
        cmd.prep = 1'b1;
        cnt_nxt  = '0;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
      end
      ST_FIN: cmd.commit = can_commit;
      default: cmd = '0;
    endcase
  end

  // Result valid: set on an emitting commit, cleared when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.commit && sts.need_emit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rotating_beacon_angle_capture.sv =====
// Sequencing: an index pulse is absorbed on accept; a light edge is captured on accept, then
//   passes through ST_PREP, ST_DIV and ST_FIN before any result it closes is made valid.
// Throughput: index pulses back to back; a light edge holds the input stalled through those
//   states, their length set by the one-bit-per-cycle restoring divider that forms the angle, and
//   longer while an earlier result is still stalled at the output.
// Reset: synchronous active-low; index times go to 0 and 1, start angle to 0, light
//   flag cleared, no result pending.
`default_nettype none

module rotating_beacon_angle_capture #(
  parameter int TIME_BITS  = 32,
  parameter int ANGLE_BITS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire rbac_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output rbac_pkg::out_t      out_data
);
  import rbac_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rbac_ctrl #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_command(in_data.command),
    .out_stall (out_stall),
    .sts       (sts),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  rbac_datapath #(
    .TIME_BITS (TIME_BITS),
    .ANGLE_BITS(ANGLE_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_data (in_data),
    .sts     (sts),
    .out_data(out_data)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/rbac_checker.sv =====
// Port-level checks for the angle capture block, bound to the top level.
`default_nettype none

module rbac_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_stall,
  input wire rbac_pkg::in_t  in_data,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire rbac_pkg::out_t out_data
);
  import rbac_pkg::*;

  // A light edge request starts a divide, so the input stalls next cycle
  a_light_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.command == CMD_LIGHT |=> in_stall)
    else $error("input not stalled after light edge");

  // An index pulse is absorbed at once
  a_index_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.command == CMD_INDEX |=> !in_stall)
    else $error("input stalled after index pulse");

  // A new result only appears at the end of a divide
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a light edge in progress");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind rotating_beacon_angle_capture rbac_checker u_rbac_checker (.*);

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the rotating beacon angle capture block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rbac_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  rotating_beacon_angle_capture uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Event requests waiting to be offered, and light arcs still to come out
  in_t  event_q[$];
  out_t arc_q[$];

  // Own copy of the sensor state
  logic [31:0] prev_index = 32'd0;
  logic [31:0] last_index = 32'd1;
  logic [15:0] held_angle = 16'd0;
  logic        lit        = 1'b0;

  logic        in_taken = 1'b0;
  logic [31:0] cyc      = '0;
  int          n_errors = 0;
  int          n_arcs   = 0;
  int          n_index  = 0;
  int          n_light  = 0;
  int          n_zero_period = 0;
  int          in_idle_left  = 0;
  int          out_hold_left = 0;
  bit          long_hold_done = 1'b0;
  out_t        want;

  initial begin
    forever #5 clk = ~clk;
  end

  // Position of a light edge as a fraction of the current revolution
  function automatic logic [15:0] beam_angle(logic [31:0] t);
    logic [31:0] delta;
    logic [31:0] period;
    logic [47:0] scaled;
    delta  = t - last_index;
    period = last_index - prev_index;
    if (delta >= period) return 16'd0;
    scaled = {delta, 16'h0000};
    return 16'(scaled / {16'h0000, period});
  endfunction

  // Update the sensor state with one accepted event, queue any arc it closes
  task automatic track_event(in_t r);
    logic [15:0] pos;
    if (r.command == CMD_INDEX) begin
      prev_index = last_index;
      last_index = r.event_time;
      n_index++;
      if (prev_index == last_index) n_zero_period++;
    end else begin
      pos = beam_angle(r.event_time);
      n_light++;
      if (r.light_absent == LIGHT_SEEN) begin
        held_angle = pos;
        lit = 1'b1;
      end else if (lit) begin
        want.onset_angle = held_angle;
        want.arc_length  = pos - held_angle;
        arc_q.push_back(want);
        lit = 1'b0;
      end
    end
  endtask

  task automatic queue_event(logic cmd, logic [31:0] t, logic lvl);
    in_t r;
    r.command      = cmd;
    r.event_time   = t;
    r.light_absent = lvl;
    event_q.push_back(r);
  endtask

  // Idle bursts are off for one stretch in four and for the tail of the run
  function automatic bit idling_allowed();
    return (event_q.size() > 150) && (cyc[9:8] != 2'b11);
  endfunction

  // Request driver
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_taken)) begin
      if (in_idle_left > 0) begin
        in_idle_left--;
        in_valid <= 1'b0;
      end else if (event_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (idling_allowed() && $urandom_range(0, 9) == 0) begin
        in_idle_left = $urandom_range(1, 16) - 1;
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_data  <= event_q.pop_front();
      end
    end
  end

  // Result receiver: random stall bursts, plus one long hold to back the block up
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_hold_left > 0) begin
        out_hold_left--;
        out_stall <= 1'b1;
      end else if (!long_hold_done && n_arcs >= 20) begin
        long_hold_done = 1'b1;
        out_hold_left  = 299;
        out_stall <= 1'b1;
      end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
        out_hold_left = $urandom_range(1, 16) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: check results against the oldest expected arc, predict accepted events
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      cyc      <= cyc + 1;
      in_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        n_arcs++;
        if (arc_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got onset_angle=%h arc_length=%h",
                   $time, out_data.onset_angle, out_data.arc_length);
          n_errors++;
        end else begin
          want = arc_q.pop_front();
          if (out_data.onset_angle !== want.onset_angle) begin
            $display("%0t: onset_angle mismatch, expected %h, got %h",
                     $time, want.onset_angle, out_data.onset_angle);
            n_errors++;
          end
          if (out_data.arc_length !== want.arc_length) begin
            $display("%0t: arc_length mismatch, expected %h, got %h",
                     $time, want.arc_length, out_data.arc_length);
            n_errors++;
          end
        end
      end
      if (in_valid && !in_stall) track_event(in_data);
    end
  end

  // Stimulus and end of run
  initial begin
    logic [31:0] t;
    logic [31:0] per;
    logic [31:0] a;
    logic [31:0] b;
    int          pairs;

    // Light lost with no light seen yet: ignored
    queue_event(CMD_LIGHT, 32'h0000_0000, LIGHT_LOST);
    // Reset period of one tick: both edges land at angle zero
    queue_event(CMD_LIGHT, 32'h0000_0001, LIGHT_SEEN);
    queue_event(CMD_LIGHT, 32'h0000_0005, LIGHT_LOST);
    // Index pulses across the time wrap, level bit set but ignored
    queue_event(CMD_INDEX, 32'hFFFF_FF00, LIGHT_LOST);
    queue_event(CMD_INDEX, 32'h0000_0100, LIGHT_LOST);
    // Arc that wraps through angle zero
    queue_event(CMD_LIGHT, 32'h0000_02FF, LIGHT_SEEN);
    queue_event(CMD_LIGHT, 32'h0000_0180, LIGHT_LOST);
    // Start angle overwritten while lit; light lost exactly one period out
    queue_event(CMD_LIGHT, 32'h0000_0140, LIGHT_SEEN);
    queue_event(CMD_LIGHT, 32'h0000_0200, LIGHT_SEEN);
    queue_event(CMD_LIGHT, 32'h0000_0300, LIGHT_LOST);
    // Zero period
    queue_event(CMD_INDEX, 32'hFFFF_FFFF, LIGHT_SEEN);
    queue_event(CMD_INDEX, 32'hFFFF_FFFF, LIGHT_SEEN);
    queue_event(CMD_LIGHT, 32'hFFFF_FFFF, LIGHT_SEEN);
    queue_event(CMD_LIGHT, 32'h0000_0000, LIGHT_LOST);
    // Largest period, angle just under a full turn
    queue_event(CMD_INDEX, 32'h0000_0000, LIGHT_SEEN);
    queue_event(CMD_INDEX, 32'hFFFF_FFFF, LIGHT_SEEN);
    queue_event(CMD_LIGHT, 32'hFFFF_FFFD, LIGHT_SEEN);
    queue_event(CMD_LIGHT, 32'h0000_0000, LIGHT_LOST);
    // Light lost again while dark
    queue_event(CMD_LIGHT, 32'h8000_0000, LIGHT_LOST);
    queue_event(CMD_LIGHT, 32'h7FFF_FFFF, LIGHT_LOST);

    // Random revolutions with light arcs inside, plus some stray events
    t   = $urandom;
    per = 1000;
    while (event_q.size() < 1220) begin
      if ($urandom_range(0, 9) < 8) begin
        case ($urandom_range(0, 9))
          0, 1: per = $urandom_range(1, 40);
          2, 3: per = $urandom_range(41, 70000);
          4, 5: per = $urandom;
          6:    per = 0;
          default: ;
        endcase
        t += per;
        queue_event(CMD_INDEX, t, 1'($urandom_range(0, 1)));
        pairs = $urandom_range(0, 3);
        repeat (pairs) begin
          a = (per == 0) ? 32'd0 : $urandom % per;
          b = (per == 0) ? 32'd0 : $urandom % per;
          if ($urandom_range(0, 7) == 0) b = per + $urandom_range(0, 3);
          queue_event(CMD_LIGHT, t + a, LIGHT_SEEN);
          queue_event(CMD_LIGHT, t + b, LIGHT_LOST);
        end
      end else begin
        queue_event(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)));
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (event_q.size() != 0 || in_valid) @(posedge clk);
    while (arc_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Covered %0d index pulses (%0d with zero period) and %0d light edges,",
             n_index, n_zero_period, n_light);
    $display("checking %0d light arcs under random idling and one long output hold.", n_arcs);
    if (n_errors == 0 && arc_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== rotating_beacon_angle_capture.f =====
hw/rtl/rbac_pkg.sv
hw/rtl/rbac_datapath.sv
hw/rtl/rbac_ctrl.sv
hw/rtl/rotating_beacon_angle_capture.sv
hw/rtl/rbac_checker.sv
sim/tb.sv
